// ----- src/mwo_pkg.sv -----
// Shared types, constants and the sine quarter-wave table for the oscillator.
package mwo_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_TAB_N      = 1 << SINE_TABLE_BITS;
  localparam int SINE_ADDR_W     = SINE_TABLE_BITS + 1;
  localparam int SINE_W          = 15;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_SELECT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_THRESHOLD  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SUBTRACT_MODE   = 3'd5;

  localparam logic [16:0] DUTY_RESET = 17'd32768;

  // Pipeline depth of the wave generator and the square-root section inside it.
  // The sixteen root digits are shared out evenly over the square-root stages.
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_STEPS  = 16 / SQRT_STAGES;
  localparam int WAVE_STAGES = SQRT_STAGES + 2;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_CIRCLE = 2'd3
  } wave_sel_t;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [31:0] phase_offset;
    logic [14:0] amplitude;
    wave_sel_t   waveform_select;
    logic [16:0] duty_threshold;
    logic        subtract_mode;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        phase;
    logic signed [15:0] sample;
  } phase_t;

  typedef struct packed {
    logic signed [15:0] wave;
    logic signed [15:0] sample;
  } wave_t;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TAB_N];

  // Quarter-wave sine in Q15, from an order-13 Taylor series in Q30 with truncating steps.
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic signed [63:0] r;
    for (int k = 0; k <= SINE_TAB_N; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      s    = $signed(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          s = s - $signed(term);
        end else begin
          s = s + $signed(term);
        end
      end
      r = (s > 0) ? ((s + 64'sd16384) >>> 15) : 64'sd0;
      if (r > 64'sd32767) begin
        r = 64'sd32767;
      end
      rom[k] = r[SINE_W-1:0];
    end
    return rom;
  endfunction

endpackage

// ----- src/mwo_if.sv -----
// Handshake channels of the oscillator: sample input, sample output and configuration writes.
interface mwo_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        time_point;
  logic signed [15:0] sample_in;

  modport source (output valid, output time_point, output sample_in, input ready);
  modport sink (input valid, input time_point, input sample_in, output ready);
endinterface

interface mwo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

interface mwo_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mwo_pkg::CFG_INDEX_W-1:0]  index;
  logic [mwo_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/mwo_phase.sv -----
// Phase accumulator stages: position = time point times phase step plus phase offset.
module mwo_phase (
  input  logic                clk,
  input  logic                rst,
  input  mwo_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         time_point,
  input  logic signed [15:0]  sample_in,
  output logic                out_valid,
  input  logic                out_ready,
  output mwo_pkg::phase_t     out_data
);

  logic [1:0]         vld;
  logic [1:0]         rdy;
  logic [31:0]        full_prod;
  logic [31:0]        prod;
  logic signed [15:0] prod_sample;
  mwo_pkg::phase_t    phase_q;

  assign rdy[1]    = !vld[1] || out_ready;
  assign rdy[0]    = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[1];
  assign out_data  = phase_q;

  // Only the low word of the product is kept: the position wraps every cycle of the wave.
  assign full_prod = time_point * cfg.phase_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod        <= full_prod;
      prod_sample <= sample_in;
    end
    if (rdy[1]) begin
      phase_q.phase  <= prod + cfg.phase_offset;
      phase_q.sample <= prod_sample;
    end
  end

endmodule

// ----- src/mwo_wave.sv -----
// Wave generator stages: sine table, square, saw and a pipelined square root for the half circle.
module mwo_wave (
  input  logic             clk,
  input  logic             rst,
  input  mwo_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  mwo_pkg::phase_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mwo_pkg::wave_t   out_data
);

  localparam mwo_pkg::sine_rom_t SINE_ROM = mwo_pkg::sine_rom_build();
  localparam logic [mwo_pkg::SINE_ADDR_W-1:0] SINE_LAST =
    mwo_pkg::SINE_ADDR_W'(mwo_pkg::SINE_TAB_N);

  typedef struct packed {
    logic [mwo_pkg::SINE_W-1:0] sine;
    logic                       neg;
    logic                       sq_hi;
    logic signed [15:0]         saw;
    mwo_pkg::wave_sel_t         sel;
    logic signed [15:0]         sample;
  } carry_t;

  typedef struct packed {
    logic [18:0] rem;
    logic [15:0] root;
    logic [31:0] rad;
  } sq_t;

  // Four digits of the restoring square root, two radicand bits per digit.
  function automatic sq_t sqrt_steps(sq_t a);
    sq_t         b;
    logic [18:0] rs;
    logic [18:0] trial;
    b = a;
    for (int j = 0; j < mwo_pkg::SQRT_STEPS; j++) begin
      rs    = {b.rem[16:0], b.rad[31:30]};
      trial = {1'b0, b.root, 2'b01};
      b.rad = {b.rad[29:0], 2'b00};
      if (rs >= trial) begin
        b.rem  = rs - trial;
        b.root = {b.root[14:0], 1'b1};
      end else begin
        b.rem  = rs;
        b.root = {b.root[14:0], 1'b0};
      end
    end
    return b;
  endfunction

  logic [mwo_pkg::WAVE_STAGES-1:0] vld;
  logic [mwo_pkg::WAVE_STAGES-1:0] rdy;

  logic [mwo_pkg::SINE_TABLE_BITS-1:0] idx;
  logic [mwo_pkg::SINE_ADDR_W-1:0]     addr;
  logic signed [15:0]                  xs;
  logic signed [31:0]                  xprod;
  carry_t                              carry_in;

  carry_t      carry [0:mwo_pkg::SQRT_STAGES];
  logic [30:0] xsq;
  sq_t         sq [0:mwo_pkg::SQRT_STAGES-1];
  sq_t         sq_next [0:mwo_pkg::SQRT_STAGES-1];

  logic signed [15:0] wave_next;
  logic [15:0]        circ;
  mwo_pkg::wave_t     wave_q;

  always_comb begin
    rdy[mwo_pkg::WAVE_STAGES-1] = !vld[mwo_pkg::WAVE_STAGES-1] || out_ready;
    for (int k = mwo_pkg::WAVE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[mwo_pkg::WAVE_STAGES-1];
  assign out_data  = wave_q;

  // Odd quadrants run the table backwards; the top bit of the position gives the sign.
  assign idx  = in_data.phase[29 -: mwo_pkg::SINE_TABLE_BITS];
  assign addr = in_data.phase[30] ? (SINE_LAST - {1'b0, idx}) : {1'b0, idx};

  assign xs    = {~in_data.phase[30], in_data.phase[29:15]};
  assign xprod = 32'(xs) * 32'(xs);

  always_comb begin
    carry_in.sine   = SINE_ROM[addr];
    carry_in.neg    = in_data.phase[31];
    carry_in.sq_hi  = {1'b0, in_data.phase} > {cfg.duty_threshold, 16'h0000};
    carry_in.saw    = {~in_data.phase[31], in_data.phase[30:16]};
    carry_in.sel    = cfg.waveform_select;
    carry_in.sample = in_data.sample;
  end

  always_comb begin
    sq_next[0] = sqrt_steps('{rem: 19'd0, root: 16'd0,
                              rad: 32'h4000_0000 - {1'b0, xsq}});
    for (int s = 1; s < mwo_pkg::SQRT_STAGES; s++) begin
      sq_next[s] = sqrt_steps(sq[s-1]);
    end
  end

  always_comb begin
    circ = sq[mwo_pkg::SQRT_STAGES-1].root[15] ? 16'h7FFF
                                               : sq[mwo_pkg::SQRT_STAGES-1].root;
    case (carry[mwo_pkg::SQRT_STAGES].sel)
      mwo_pkg::WAVE_SINE: begin
        wave_next = carry[mwo_pkg::SQRT_STAGES].neg
                  ? -$signed({1'b0, carry[mwo_pkg::SQRT_STAGES].sine})
                  :  $signed({1'b0, carry[mwo_pkg::SQRT_STAGES].sine});
      end
      mwo_pkg::WAVE_SQUARE: begin
        wave_next = carry[mwo_pkg::SQRT_STAGES].sq_hi ? 16'sd32767 : -16'sd32767;
      end
      mwo_pkg::WAVE_SAW: begin
        wave_next = carry[mwo_pkg::SQRT_STAGES].saw;
      end
      mwo_pkg::WAVE_CIRCLE: begin
        wave_next = carry[mwo_pkg::SQRT_STAGES].neg ? -$signed(circ) : $signed(circ);
      end
      default: begin
        wave_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < mwo_pkg::WAVE_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      carry[0] <= carry_in;
      xsq      <= xprod[30:0];
    end
    for (int s = 0; s < mwo_pkg::SQRT_STAGES; s++) begin
      if (rdy[s+1]) begin
        sq[s]      <= sq_next[s];
        carry[s+1] <= carry[s];
      end
    end
    if (rdy[mwo_pkg::WAVE_STAGES-1]) begin
      wave_q.wave   <= wave_next;
      wave_q.sample <= carry[mwo_pkg::SQRT_STAGES].sample;
    end
  end

endmodule

// ----- src/mwo_mix.sv -----
// Output stages: amplitude scaling with rounding, then a saturating add or subtract.
module mwo_mix (
  input  logic               clk,
  input  logic               rst,
  input  mwo_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  mwo_pkg::wave_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  output logic               saturated
);

  logic [1:0]         vld;
  logic [1:0]         rdy;
  logic signed [31:0] prod;
  logic signed [15:0] prod_sample;
  logic signed [31:0] rounded;
  logic signed [16:0] scaled;
  logic signed [17:0] sum;
  logic signed [15:0] result_next;
  logic               sat_next;
  logic signed [15:0] result;
  logic               sat;

  assign rdy[1]     = !vld[1] || out_ready;
  assign rdy[0]     = !vld[0] || rdy[1];
  assign in_ready   = rdy[0];
  assign out_valid  = vld[1];
  assign sample_out = result;
  assign saturated  = sat;

  // Round half up, then a flooring shift back to Q15.
  assign rounded = prod + 32'sd16384;
  assign scaled  = rounded[31:15];

  always_comb begin
    if (cfg.subtract_mode) begin
      sum = 18'(prod_sample) - 18'(scaled);
    end else begin
      sum = 18'(prod_sample) + 18'(scaled);
    end
    if (sum > 18'sd32767) begin
      result_next = 16'sh7FFF;
      sat_next    = 1'b1;
    end else if (sum < -18'sd32768) begin
      result_next = 16'sh8000;
      sat_next    = 1'b1;
    end else begin
      result_next = sum[15:0];
      sat_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod        <= 32'(in_data.wave) * $signed(32'(cfg.amplitude));
      prod_sample <= in_data.sample;
    end
    if (rdy[1]) begin
      result <= result_next;
      sat    <= sat_next;
    end
  end

endmodule

// ----- src/multi_waveform_oscillator.sv -----
// Top level of the multi-waveform oscillator: configuration registers and the stage chain.
//
//   Channel  Direction  Payload                         Beat taken when
//   din      sink       time_point[31:0], sample_in[15:0]  din.valid & din.ready
//   dout     source     sample_out[15:0], saturated        dout.valid & dout.ready
//   cfg      sink       index[2:0], data[31:0]              cfg.valid & cfg.ready
//
// An accepted input beat passes two phase stages, six wave stages (four of them the
// square-root digits) and two mixing stages; one beat a cycle is sustained while the
// output is ready. Every stage carries a valid bit and loads whenever it is empty or
// the stage after it moves, so a stalled output only holds what is queued behind it.
// Reset is synchronous, clears the valid bits and returns the configuration registers to
// their reset values; the configuration port is always ready.
module multi_waveform_oscillator (
  input logic           clk,
  input logic           rst,
  mwo_in_if.sink        din,
  mwo_out_if.source     dout,
  mwo_cfg_if.sink       cfg
);

  mwo_pkg::cfg_t   cfg_r;

  logic            ph_valid;
  logic            ph_ready;
  mwo_pkg::phase_t ph_data;
  logic            wv_valid;
  logic            wv_ready;
  mwo_pkg::wave_t  wv_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.phase_step      <= '0;
      cfg_r.phase_offset    <= '0;
      cfg_r.amplitude       <= '0;
      cfg_r.waveform_select <= mwo_pkg::WAVE_SINE;
      cfg_r.duty_threshold  <= mwo_pkg::DUTY_RESET;
      cfg_r.subtract_mode   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mwo_pkg::REG_PHASE_STEP:      cfg_r.phase_step      <= cfg.data;
        mwo_pkg::REG_PHASE_OFFSET:    cfg_r.phase_offset    <= cfg.data;
        mwo_pkg::REG_AMPLITUDE:       cfg_r.amplitude       <= cfg.data[14:0];
        mwo_pkg::REG_WAVEFORM_SELECT: begin
          cfg_r.waveform_select <= mwo_pkg::wave_sel_t'(cfg.data[1:0]);
        end
        mwo_pkg::REG_DUTY_THRESHOLD:  cfg_r.duty_threshold  <= cfg.data[16:0];
        mwo_pkg::REG_SUBTRACT_MODE:   cfg_r.subtract_mode   <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  mwo_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_r),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .time_point (din.time_point),
    .sample_in  (din.sample_in),
    .out_valid  (ph_valid),
    .out_ready  (ph_ready),
    .out_data   (ph_data)
  );

  mwo_wave u_wave (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_r),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .in_data   (ph_data),
    .out_valid (wv_valid),
    .out_ready (wv_ready),
    .out_data  (wv_data)
  );

  mwo_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_r),
    .in_valid   (wv_valid),
    .in_ready   (wv_ready),
    .in_data    (wv_data),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .sample_out (dout.sample_out),
    .saturated  (dout.saturated)
  );

endmodule

// ----- tb/osc_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the oscillator: mirrors the registers, predicts every output beat and compares.
module osc_checker (
  input  logic clk,
  input  logic rst,
  mwo_in_if    din,
  mwo_out_if   dout,
  mwo_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding,
  output int   checked
);

  localparam logic [63:0] HALF_PI_FIX = 64'd1686629713;
  localparam int          QUARTER     = 1 << mwo_pkg::SINE_TABLE_BITS;
  localparam int          ADDR_W      = mwo_pkg::SINE_TABLE_BITS + 1;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               saturated;
  } mix_t;

  logic [14:0]   quarter_sine [0:QUARTER];
  mwo_pkg::cfg_t shadow;
  mix_t          pending_mix[$];
  mix_t          want;
  int            fail_total    = 0;
  int            checked_total = 0;
  int            queued        = 0;

  assign mismatches  = fail_total;
  assign outstanding = queued;
  assign checked     = checked_total;

  // One quarter-wave entry: odd Taylor terms up to x^13 in Q30, each step truncated.
  function automatic logic [14:0] sine_entry(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      s;
    longint      r;
    x    = (HALF_PI_FIX * 64'(k)) >> mwo_pkg::SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    r = (s > 0) ? ((s + 16384) >>> 15) : 0;
    if (r > 32767) begin
      r = 32767;
    end
    return r[14:0];
  endfunction

  // Largest y with y*y <= v, found by bisection.
  function automatic int root_floor(longint v);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return int'(lo);
  endfunction

  function automatic int wave_at(logic [31:0] p);
    int               level;
    int               x;
    logic [ADDR_W-1:0] addr;
    case (shadow.waveform_select)
      mwo_pkg::WAVE_SINE: begin
        addr = {1'b0, p[29 -: mwo_pkg::SINE_TABLE_BITS]};
        if (p[30]) begin
          addr = ADDR_W'(QUARTER) - addr;
        end
        level = int'(quarter_sine[addr]);
        if (p[31]) begin
          level = -level;
        end
      end
      mwo_pkg::WAVE_SQUARE: begin
        level = (64'(p) > (64'(shadow.duty_threshold) << 16)) ? 32767 : -32767;
      end
      mwo_pkg::WAVE_SAW: begin
        level = int'(p[31:16]) - 32768;
      end
      default: begin
        x     = int'(p[30:15]) - 32768;
        level = root_floor((longint'(1) << 30) - longint'(x) * longint'(x));
        if (level > 32767) begin
          level = 32767;
        end
        if (p[31]) begin
          level = -level;
        end
      end
    endcase
    return level;
  endfunction

  function automatic mix_t mix_predict(logic [31:0] tp, logic signed [15:0] smp);
    logic [31:0] p;
    longint      scaled;
    longint      total;
    mix_t        res;
    p      = tp * shadow.phase_step + shadow.phase_offset;
    scaled = (longint'(wave_at(p)) * longint'(shadow.amplitude) + 16384) >>> 15;
    total  = shadow.subtract_mode ? longint'(smp) - scaled : longint'(smp) + scaled;
    res.saturated = 1'b0;
    if (total > 32767) begin
      res.sample_out = 16'sh7FFF;
      res.saturated  = 1'b1;
    end else if (total < -32768) begin
      res.sample_out = 16'sh8000;
      res.saturated  = 1'b1;
    end else begin
      res.sample_out = 16'(total);
    end
    return res;
  endfunction

  task automatic apply_write(logic [mwo_pkg::CFG_INDEX_W-1:0] idx,
                             logic [mwo_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      mwo_pkg::REG_PHASE_STEP:      shadow.phase_step      = value;
      mwo_pkg::REG_PHASE_OFFSET:    shadow.phase_offset    = value;
      mwo_pkg::REG_AMPLITUDE:       shadow.amplitude       = value[14:0];
      mwo_pkg::REG_WAVEFORM_SELECT: shadow.waveform_select = mwo_pkg::wave_sel_t'(value[1:0]);
      mwo_pkg::REG_DUTY_THRESHOLD:  shadow.duty_threshold  = value[16:0];
      mwo_pkg::REG_SUBTRACT_MODE:   shadow.subtract_mode   = value[0];
      default: ;
    endcase
  endtask

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_total++;
  endtask

  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_sine[k] = sine_entry(k);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      shadow.phase_step      = '0;
      shadow.phase_offset    = '0;
      shadow.amplitude       = '0;
      shadow.waveform_select = mwo_pkg::WAVE_SINE;
      shadow.duty_threshold  = mwo_pkg::DUTY_RESET;
      shadow.subtract_mode   = 1'b0;
      pending_mix.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        apply_write(cfg.index, cfg.data);
      end
      if (din.valid && din.ready) begin
        pending_mix.insert(pending_mix.size(), mix_predict(din.time_point, din.sample_in));
      end
      if (dout.valid && dout.ready) begin
        if (pending_mix.size() == 0) begin
          report("output beat arrived with no input beat outstanding");
        end else begin
          want = pending_mix.pop_front();
          if (dout.sample_out !== want.sample_out) begin
            report($sformatf("result %0d: sample_out %0d, expected %0d",
                             checked_total, dout.sample_out, want.sample_out));
          end
          if (dout.saturated !== want.saturated) begin
            report($sformatf("result %0d: saturated %b, expected %b",
                             checked_total, dout.saturated, want.saturated));
          end
          checked_total++;
        end
      end
    end
    queued <= pending_mix.size();
  end

endmodule

// ----- tb/tb_multi_waveform_oscillator.sv -----
`timescale 1ns / 1ps
// Testbench top for the oscillator: clock, reset, register phases, sample stimulus and verdict.
module tb_multi_waveform_oscillator;

  localparam int ITEM_TOTAL   = 1450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [mwo_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [mwo_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  int   checked;
  int   items_sent = 0;
  int   settings   = 0;
  int   burst_left = 0;

  mwo_in_if  din_ch ();
  mwo_out_if dout_ch ();
  mwo_cfg_if cfg_ch ();

  multi_waveform_oscillator dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_ch),
    .dout (dout_ch),
    .cfg  (cfg_ch)
  );

  osc_checker chk (
    .clk         (clk),
    .rst         (rst),
    .din         (din_ch),
    .dout        (dout_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always #6 clk = ~clk;

  // Leaves valid high so that back-to-back writes need no second assignment in one step.
  task automatic write_reg(logic [mwo_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_regs(logic [31:0] step, logic [31:0] offset, logic [31:0] amp,
                          logic [31:0] sel, logic [31:0] duty, logic [31:0] sub);
    write_reg(mwo_pkg::REG_PHASE_STEP, step);
    write_reg(mwo_pkg::REG_PHASE_OFFSET, offset);
    write_reg(mwo_pkg::REG_AMPLITUDE, amp);
    write_reg(mwo_pkg::REG_WAVEFORM_SELECT, sel);
    write_reg(mwo_pkg::REG_DUTY_THRESHOLD, duty);
    write_reg(mwo_pkg::REG_SUBTRACT_MODE, sub);
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  task automatic write_one(logic [mwo_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
    write_reg(idx, value);
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  // Bursts of random length, occasionally long ones, separated by short random gaps.
  task automatic send_item(logic [31:0] tp, logic [15:0] smp);
    if (burst_left == 0) begin
      din_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 300)
                                                 : $urandom_range(1, 24);
    end
    din_ch.valid      <= 1'b1;
    din_ch.time_point <= tp;
    din_ch.sample_in  <= smp;
    do @(posedge clk); while (!din_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending and let every expected beat come back before the registers change.
  task automatic end_phase();
    din_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0:       w = 32'h0000_0000;
      1:       w = 32'hFFFF_FFFF;
      2:       w = $urandom_range(1, 1 << 20);
      default: w = $urandom();
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_point();
    logic [31:0] w;
    case ($urandom_range(0, 15))
      0:       w = 32'h0000_0000;
      1:       w = 32'hFFFF_FFFF;
      default: w = $urandom();
    endcase
    return w;
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] w;
    case ($urandom_range(0, 7))
      0:       w = 16'h7FFF;
      1:       w = 16'h8000;
      default: w = 16'($urandom());
    endcase
    return w;
  endfunction

  task automatic directed_items();
    // Reset settings give zero gain, so the incoming sample passes straight through.
    send_item(32'h0000_0000, 16'h7FFF);
    send_item(32'hFFFF_FFFF, 16'h8000);
    end_phase();

    // A unit step makes the time point the cycle position: visit each quadrant of the sine.
    set_regs(32'd1, 32'd0, 32'h7FFF, 32'(mwo_pkg::WAVE_SINE), 32'd0, 32'd0);
    send_item(32'h0000_0000, 16'h7FFF);
    send_item(32'h4000_0000, 16'h7FFF);
    send_item(32'h8000_0000, 16'h8000);
    send_item(32'hC000_0000, 16'h8000);
    send_item(32'h3FFF_FFFF, 16'h0000);
    end_phase();

    // Zero threshold: the square is low only at the very start of the cycle.
    set_regs(32'd1, 32'd0, 32'h7FFF, 32'(mwo_pkg::WAVE_SQUARE), 32'd0, 32'd0);
    send_item(32'h0000_0000, 16'h8000);
    send_item(32'h0000_0001, 16'h7FFF);
    end_phase();

    // Threshold of one, and beyond one after the upper data bits are dropped.
    write_one(mwo_pkg::REG_DUTY_THRESHOLD, 32'h0001_0000);
    send_item(32'hFFFF_FFFF, 16'h0000);
    end_phase();
    write_one(mwo_pkg::REG_DUTY_THRESHOLD, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 16'h8000);
    end_phase();
    write_one(mwo_pkg::REG_DUTY_THRESHOLD, 32'h0000_8000);
    send_item(32'h8000_0000, 16'h0000);
    send_item(32'h8000_0001, 16'h0000);
    end_phase();

    // Saw in subtract mode, driven into both rails.
    set_regs(32'd1, 32'd0, 32'h7FFF, 32'(mwo_pkg::WAVE_SAW), 32'h0000_8000, 32'd1);
    send_item(32'h0000_0000, 16'h7FFF);
    send_item(32'hFFFF_FFFF, 16'h8000);
    end_phase();

    // Half circle, including its capped peak at the quarter points.
    set_regs(32'd1, 32'd0, 32'h7FFF, 32'(mwo_pkg::WAVE_CIRCLE), 32'h0000_8000, 32'd0);
    send_item(32'h0000_0000, 16'h0000);
    send_item(32'h4000_0000, 16'h7FFF);
    send_item(32'h8000_0000, 16'h0000);
    send_item(32'hC000_0000, 16'h8000);
    send_item(32'hFFFF_FFFF, 16'h0000);
    end_phase();

    // Writes beyond the last register, then the largest step and offset.
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h0000_0000);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'(mwo_pkg::WAVE_SINE),
             32'd0, 32'd1);
    send_item(32'h0000_0000, 16'h0000);
    send_item(32'hFFFF_FFFF, 16'h7FFF);
    end_phase();
  endtask

  task automatic random_config();
    logic [31:0] v [6];
    for (int i = 0; i < 6; i++) begin
      v[i] = rand_word();
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom());
    end
    set_regs(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  // Output back-pressure in four styles; the style in use is redrawn at random.
  initial begin : stall_pattern
    int style;
    int tick;
    style = 0;
    tick  = 0;
    dout_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 200 == 0) begin
        style = $urandom_range(0, 3);
      end
      case (style)
        0:       dout_ch.ready <= 1'b1;
        1:       dout_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       dout_ch.ready <= (tick % 7 < 2);
        default: dout_ch.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timed out after %0d idle cycles.", IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase_len;
    din_ch.valid      <= 1'b0;
    din_ch.time_point <= '0;
    din_ch.sample_in  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed_items();
    while (items_sent < ITEM_TOTAL) begin
      random_config();
      phase_len = $urandom_range(60, 200);
      if (phase_len > ITEM_TOTAL - items_sent) begin
        phase_len = ITEM_TOTAL - items_sent;
      end
      repeat (phase_len) send_item(rand_point(), rand_sample());
      end_phase();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats and %0d checked results over %0d register settings.",
             items_sent, checked, settings);
    $display("Sine, square, saw and half circle were mixed by adding and subtracting.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mwo_pkg.sv
src/mwo_if.sv
src/mwo_phase.sv
src/mwo_wave.sv
src/mwo_mix.sv
src/multi_waveform_oscillator.sv
tb/osc_checker.sv
tb/tb_multi_waveform_oscillator.sv
